/* hdl/rmn_pkg.sv */
// Shared types and constants for the RGB max-normalise block.
// Used by the controller, the datapath, the top level, the checker and the testbench; depends on nothing.
package rmn_pkg;

   localparam int NUM_CH     = 3;
   localparam int IN_W       = 24;
   localparam int OUT_W      = 8;
   localparam int REQ_DATA_W = NUM_CH * IN_W;
   localparam int RSP_DATA_W = NUM_CH * OUT_W;
   localparam int REQ_USER_W = 2;
   localparam int GAIN_W     = 8;

   // tuser bit positions on the request side
   localparam int USER_MODE  = 0;
   localparam int USER_START = 1;

   localparam logic MODE_MEASURE = 1'b0;
   localparam logic MODE_MAP     = 1'b1;

   localparam logic [OUT_W-1:0] FULL_SCALE = 8'd255;

   // Controller to datapath commands
   typedef struct packed {
      logic measure;     // fold the input counts into the maxima
      logic capture;     // hold the input counts for a map transfer
      logic div_start;   // load maxima / gain into the dividers
      logic div_step;    // one restoring step on every lane
      logic fac_start;   // load 255 / quotient into the dividers
      logic fac_finish;  // latch the per-channel factors
      logic out_load;    // scale the held counts into the output register
   } rmn_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;    // output register can take a result this cycle
   } rmn_status_type;

endpackage

/* hdl/rmn_ctrl.sv */
// Sequencer for the RGB max-normalise block: handshake, factor cache, divider steps.
// Depends on rmn_pkg; drives the datapath through rmn_cmd_type.
module rmn_ctrl #(
   parameter int COUNT_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_mode,
   input  logic                    csr_we,
   input  rmn_pkg::rmn_status_type status,
   output rmn_pkg::rmn_cmd_type    cmd
);
   import rmn_pkg::*;

   localparam int CNT_W = $clog2(COUNT_BITS);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV_MAX  = 3'd1;
   localparam logic [2:0] S_FAC_LOAD = 3'd2;
   localparam logic [2:0] S_DIV_FAC  = 3'd3;
   localparam logic [2:0] S_FAC_DONE = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             fac_valid_ff, fac_valid_in;
   logic             pend_ff, pend_in;
   logic             accept;

   assign req_tready = (state_ff == S_IDLE) && (!pend_ff || status.out_free);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fac_valid_in = fac_valid_ff;
      cmd          = '0;
      cmd.out_load = pend_ff && status.out_free;
      pend_in      = pend_ff && !cmd.out_load;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_MEASURE) begin
                  cmd.measure  = 1'b1;
                  fac_valid_in = 1'b0;
               end else begin
                  cmd.capture = 1'b1;
                  if (fac_valid_ff) begin
                     pend_in = 1'b1;
                  end else begin
                     cmd.div_start = 1'b1;
                     cnt_in        = CNT_W'(COUNT_BITS - 1);
                     state_in      = S_DIV_MAX;
                  end
               end
            end
         end
         S_DIV_MAX: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FAC_LOAD;
            end
         end
         S_FAC_LOAD: begin
            cmd.fac_start = 1'b1;
            cnt_in        = CNT_W'(OUT_W - 1);
            state_in      = S_DIV_FAC;
         end
         S_DIV_FAC: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FAC_DONE;
            end
         end
         S_FAC_DONE: begin
            cmd.fac_finish = 1'b1;
            fac_valid_in   = 1'b1;
            pend_in        = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new gain makes the cached factors stale
      if (csr_we) begin
         fac_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fac_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fac_valid_ff <= fac_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

/* hdl/rmn_datapath.sv */
// Datapath of the RGB max-normalise block: maxima, gain, three bit-serial dividers,
// factor cache and the output register. Depends on rmn_pkg.
module rmn_datapath #(
   parameter int COUNT_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rmn_pkg::rmn_cmd_type             cmd,
   output rmn_pkg::rmn_status_type          status,
   input  logic [rmn_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_start,
   input  logic                             csr_we,
   input  logic [rmn_pkg::GAIN_W-1:0]       csr_wdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rmn_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rmn_pkg::*;

   localparam int PROD_W = COUNT_BITS + OUT_W;

   logic [GAIN_W-1:0]     gain_ff, gain_in, gain_eff;
   logic [COUNT_BITS-1:0] max_ff [NUM_CH];
   logic [COUNT_BITS-1:0] max_in [NUM_CH];
   logic [COUNT_BITS-1:0] val_ff [NUM_CH];
   logic [COUNT_BITS-1:0] val_in [NUM_CH];
   logic [COUNT_BITS-1:0] num_ff [NUM_CH];
   logic [COUNT_BITS-1:0] num_in [NUM_CH];
   logic [OUT_W-1:0]      rem_ff [NUM_CH];
   logic [OUT_W-1:0]      rem_in [NUM_CH];
   logic [OUT_W-1:0]      div_ff [NUM_CH];
   logic [OUT_W-1:0]      div_in [NUM_CH];
   logic [OUT_W-1:0]      fac_ff [NUM_CH];
   logic [OUT_W-1:0]      fac_in [NUM_CH];
   logic [NUM_CH-1:0]     zero_ff, zero_in, big_ff, big_in;
   logic [OUT_W-1:0]      out_ff [NUM_CH];
   logic [OUT_W-1:0]      out_in [NUM_CH];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] count [NUM_CH];
   logic [OUT_W:0]        trial [NUM_CH];
   logic                  ge [NUM_CH];
   logic [PROD_W-1:0]     prod [NUM_CH];

   assign gain_eff        = (gain_ff == '0) ? GAIN_W'(1) : gain_ff;
   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = {out_ff[2], out_ff[1], out_ff[0]};

   always_comb begin
      gain_in      = csr_we ? csr_wdata : gain_ff;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      zero_in      = zero_ff;
      big_in       = big_ff;
      for (int l = 0; l < NUM_CH; l++) begin
         count[l] = COUNT_BITS'(req_tdata[l*IN_W +: IN_W]);
         // restoring step: shift the next numerator bit into the remainder
         trial[l] = {rem_ff[l], num_ff[l][COUNT_BITS-1]};
         ge[l]    = trial[l] >= {1'b0, div_ff[l]};
         prod[l]  = PROD_W'(fac_ff[l]) * PROD_W'(val_ff[l]);

         max_in[l] = max_ff[l];
         val_in[l] = val_ff[l];
         num_in[l] = num_ff[l];
         rem_in[l] = rem_ff[l];
         div_in[l] = div_ff[l];
         fac_in[l] = fac_ff[l];
         out_in[l] = out_ff[l];

         if (cmd.measure) begin
            if (req_start || (count[l] > max_ff[l])) begin
               max_in[l] = count[l];
            end
         end
         if (cmd.capture) begin
            val_in[l] = count[l];
         end
         if (cmd.div_start) begin
            num_in[l] = max_ff[l];
            rem_in[l] = '0;
            div_in[l] = gain_eff;
         end
         if (cmd.div_step) begin
            num_in[l] = {num_ff[l][COUNT_BITS-2:0], ge[l]};
            rem_in[l] = ge[l] ? OUT_W'(trial[l] - {1'b0, div_ff[l]}) : trial[l][OUT_W-1:0];
         end
         if (cmd.fac_start) begin
            // num holds the channel quotient; now divide full scale by it
            zero_in[l] = (num_ff[l] == '0);
            big_in[l]  = (num_ff[l] > COUNT_BITS'(FULL_SCALE));
            num_in[l]  = COUNT_BITS'(FULL_SCALE) << (COUNT_BITS - OUT_W);
            rem_in[l]  = '0;
            div_in[l]  = num_ff[l][OUT_W-1:0];
         end
         if (cmd.fac_finish) begin
            // a zero quotient saturates any nonzero count, keeps zero at zero
            if (zero_ff[l]) begin
               fac_in[l] = FULL_SCALE;
            end else if (big_ff[l]) begin
               fac_in[l] = '0;
            end else begin
               fac_in[l] = num_ff[l][OUT_W-1:0];
            end
         end
         if (cmd.out_load) begin
            out_in[l] = (prod[l] > PROD_W'(FULL_SCALE)) ? FULL_SCALE : prod[l][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= GAIN_W'(1);
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < NUM_CH; l++) begin
            max_ff[l] <= '0;
         end
      end else begin
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int l = 0; l < NUM_CH; l++) begin
            max_ff[l] <= max_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      big_ff  <= big_in;
      for (int l = 0; l < NUM_CH; l++) begin
         val_ff[l] <= val_in[l];
         num_ff[l] <= num_in[l];
         rem_ff[l] <= rem_in[l];
         div_ff[l] <= div_in[l];
         fac_ff[l] <= fac_in[l];
         out_ff[l] <= out_in[l];
      end
   end

endmodule

/* hdl/rgb_max_normalize_with_gain.sv */
// Per-channel max normalisation with gain for an RGB hit-count image.
// The frame is streamed twice over the req_ channel. In the measure pass
// (tuser mode = 0) each transfer raises three running maxima; start_frame on
// a measure transfer clears them first. Measure transfers give no result.
// In the map pass (mode = 1) each transfer gives one rsp_ transfer with
// min(255, (255 / (max / gain)) * count) per channel.
// csr_we / csr_wdata write the gain; write it only while the block is idle.
// The per-channel factors are cached. The first map
// transfer after any measure transfer or gain write rebuilds them with three
// bit-serial restoring dividers, one quotient bit per cycle: COUNT_BITS steps
// for max / gain, 8 steps for 255 / quotient, with a load step before each
// division and a latch step after. With the factors cached a map transfer
// is taken every cycle while the receiver takes results; its result waits in
// the pending flag, then the 8 x COUNT_BITS multiplier feeds the output register.
// Reset clears the maxima, sets the gain to 1, empties the output register
// and drops the cache. When the receiver stalls, hold the result in the
// output register; measure transfers are still taken until one map transfer
// parks behind the held result, and then req_tready falls for every transfer
// until rsp_tready returns.
module rgb_max_normalize_with_gain #(
   parameter int COUNT_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rmn_pkg::REQ_DATA_W-1:0]   req_tdata,  // red_in, green_in, blue_in
   input  logic [rmn_pkg::REQ_USER_W-1:0]   req_tuser,  // mode, start_frame
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rmn_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // red_out, green_out, blue_out
   // gain register
   input  logic                             csr_we,
   input  logic [rmn_pkg::GAIN_W-1:0]       csr_wdata
);
   import rmn_pkg::*;

   rmn_cmd_type    cmd;
   rmn_status_type status;

   // sequencing: handshake, factor cache, divider step count
   rmn_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser[USER_MODE]),
      .csr_we     (csr_we),
      .status     (status),
      .cmd        (cmd)
   );

   // maxima, dividers, factors and the output register
   rmn_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_start  (req_tuser[USER_START]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/rmn_checker.sv */
// Port-level checks for the RGB max-normalise block, bound to the top level.
// Depends on rmn_pkg for the port widths.
module rmn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rmn_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import rmn_pkg::*;

   // a stalled result stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result present after reset");

   // the block is ready for a transfer right after reset
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("not ready after reset");

endmodule

bind rgb_max_normalize_with_gain rmn_checker u_rmn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/rgb_max_normalize_with_gain_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for rgb_max_normalize_with_gain: a directed table, then random
// frames streamed as a measure pass and a map pass, checked against an in-bench predictor.
// Depends on rmn_pkg and the block under test only.
module rgb_max_normalize_with_gain_test;
   import rmn_pkg::*;

   localparam int COUNT_BITS    = 24;
   localparam int TARGET_ITEMS  = 720;     // directed plus random pixel transfers
   localparam int SETTLE_CYCLES = COUNT_BITS + 16;  // factor rebuild plus margin
   localparam int LONG_HOLD     = 300;     // receiver hold-off, long enough to fill the block
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      logic            mode;
      logic            start;
      logic [IN_W-1:0] red;
      logic [IN_W-1:0] green;
      logic [IN_W-1:0] blue;
   } pixel_type;

   // red in the top byte, blue in the bottom byte
   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_type;

   typedef enum logic {ROW_PIXEL, ROW_GAIN} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      pixel_type         pix;
      logic [GAIN_W-1:0] gain;
      bit                known;   // expected colour typed into the table
      rgb_type           want;
   } stim_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // red_in, green_in, blue_in
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // mode, start_frame
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // red_out, green_out, blue_out
   logic                  csr_we     = 1'b0;
   logic [GAIN_W-1:0]     csr_wdata  = '0;

   // Predictor state: running maxima and the gain register as the block should hold them
   logic [IN_W-1:0]   peak_red   = '0;
   logic [IN_W-1:0]   peak_green = '0;
   logic [IN_W-1:0]   peak_blue  = '0;
   logic [GAIN_W-1:0] gain_now   = 8'd1;

   rgb_type      expected_rgb[$];
   stim_row_type directed_rows[$];

   int  errors         = 0;
   int  cycle_count    = 0;
   int  pixels_sent    = 0;
   int  measures_sent  = 0;
   int  maps_sent      = 0;
   int  gain_writes    = 0;
   int  results_seen   = 0;
   int  req_steady     = 0;
   int  rsp_steady     = 0;
   int  rsp_hold       = 0;
   int  rsp_roll;
   bit  hold_rsp_long  = 1'b0;
   bit  hold_done      = 1'b0;
   rgb_type rsp_want;
   rgb_type rsp_got;

   rgb_max_normalize_with_gain #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                  cycle_count, expected_rgb.size());
         $display("FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // One channel: divide the peak by the gain, then scale the count by 255 / quotient.
   // A zero quotient saturates any nonzero count; a gain of zero acts as one.
   function automatic logic [OUT_W-1:0] scale_count(input logic [IN_W-1:0] count,
                                                    input logic [IN_W-1:0] peak);
      logic [IN_W-1:0] gain_eff;
      logic [IN_W-1:0] quotient;
      logic [39:0]     product;
      gain_eff = IN_W'(gain_now);
      if (gain_eff == '0)
         gain_eff = IN_W'(1);
      quotient = peak / gain_eff;
      if (quotient == '0)
         return (count != '0) ? FULL_SCALE : '0;
      product = (40'(FULL_SCALE) / 40'(quotient)) * 40'(count);
      return (product > 40'(FULL_SCALE)) ? FULL_SCALE : product[OUT_W-1:0];
   endfunction

   // Fold a measure pixel into the maxima, or map a pixel; returns 1 when a result is due
   function automatic bit normalise_pixel(input pixel_type p, output rgb_type mapped);
      mapped = '0;
      if (p.mode == MODE_MEASURE) begin
         if (p.start) begin
            peak_red   = '0;
            peak_green = '0;
            peak_blue  = '0;
         end
         if (p.red > peak_red)     peak_red   = p.red;
         if (p.green > peak_green) peak_green = p.green;
         if (p.blue > peak_blue)   peak_blue  = p.blue;
         return 1'b0;
      end
      mapped.red   = scale_count(p.red, peak_red);
      mapped.green = scale_count(p.green, peak_green);
      mapped.blue  = scale_count(p.blue, peak_blue);
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------------------

   // Mostly short stalls, now and then a long one
   function automatic int stall_length();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic int req_gap();
      if (req_steady > 0) begin
         req_steady--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         req_steady = $urandom_range(20, 60);
         return 0;
      end
      return ($urandom_range(0, 99) < 60) ? 0 : stall_length();
   endfunction

   // Offer one pixel, hold it until the transfer happens, then predict its result
   task automatic send_pixel(input pixel_type p, input bit known, input rgb_type want);
      int                    gap;
      logic [REQ_USER_W-1:0] user;
      rgb_type               mapped;
      gap = req_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      user             = '0;
      user[USER_MODE]  = p.mode;
      user[USER_START] = p.start;
      req_tvalid <= 1'b1;
      req_tdata  <= {p.blue, p.green, p.red};
      req_tuser  <= user;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer taken at this edge
      if (normalise_pixel(p, mapped))
         expected_rgb.push_back(known ? want : mapped);
      pixels_sent++;
      if (p.mode == MODE_MEASURE) measures_sent++;
      else maps_sent++;
   endtask

   // Drop valid, wait for every result, then let a factor rebuild run out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(input logic [GAIN_W-1:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we   <= 1'b0;
      gain_now = value;
      gain_writes++;
   endtask

   task automatic add_pixel_row(input logic mode, input logic start,
                                input logic [IN_W-1:0] red, input logic [IN_W-1:0] green,
                                input logic [IN_W-1:0] blue, input bit known,
                                input rgb_type want);
      stim_row_type row;
      row.kind  = ROW_PIXEL;
      row.pix   = {mode, start, red, green, blue};
      row.gain  = '0;
      row.known = known;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_gain_row(input logic [GAIN_W-1:0] value);
      stim_row_type row;
      row.kind  = ROW_GAIN;
      row.pix   = '0;
      row.gain  = value;
      row.known = 1'b0;
      row.want  = '0;
      directed_rows.push_back(row);
   endtask

   function automatic logic [IN_W-1:0] rand_count(input int bits);
      logic [IN_W-1:0] mask;
      mask = (bits >= IN_W) ? '1 : ((IN_W'(1) << bits) - IN_W'(1));
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return mask;
         default: return IN_W'($urandom) & mask;
      endcase
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 8'd1;
         2:       return 8'd255;
         default: return GAIN_W'($urandom_range(1, 255));
      endcase
   endfunction

   // One frame: a measure pass over its pixels, then a map pass over the same pixels.
   // Now and then skip the measure pass, drop or misplace the start flag, map an
   // off-sample count or slip a stray measure transfer into the map pass.
   task automatic run_frame(input bit arm_hold);
      pixel_type frame_px[$];
      pixel_type p;
      pixel_type stray;
      int        n;
      int        bits;
      n    = arm_hold ? 12 : $urandom_range(1, 12);
      bits = $urandom_range(1, IN_W);
      repeat (n) begin
         p.mode  = MODE_MEASURE;
         p.start = 1'b0;
         p.red   = rand_count(bits);
         p.green = rand_count(bits);
         p.blue  = rand_count(bits);
         frame_px.push_back(p);
      end
      if ($urandom_range(0, 9) != 0) begin
         for (int i = 0; i < n; i++) begin
            p       = frame_px[i];
            p.mode  = MODE_MEASURE;
            p.start = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0);
            send_pixel(p, 1'b0, '0);
         end
      end
      // stall the receiver while the whole map pass is offered
      if (arm_hold)
         hold_rsp_long = 1'b1;
      for (int i = 0; i < n; i++) begin
         p       = frame_px[i];
         p.mode  = MODE_MAP;
         p.start = ($urandom_range(0, 1) != 0);
         if ($urandom_range(0, 7) == 0) begin
            p.red   = rand_count(IN_W);
            p.green = rand_count(bits);
            p.blue  = rand_count(IN_W);
         end
         send_pixel(p, 1'b0, '0);
         if ($urandom_range(0, 24) == 0) begin
            stray.mode  = MODE_MEASURE;
            stray.start = 1'b0;
            stray.red   = rand_count(bits);
            stray.green = rand_count(bits);
            stray.blue  = rand_count(bits);
            send_pixel(stray, 1'b0, '0);
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver side: check each result transfer, then choose the next tready
   // ---------------------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_rgb.size() == 0) begin
            $display("%0t: result with nothing expected, got %h", $time, rsp_tdata);
            errors++;
         end else begin
            rsp_want = expected_rgb.pop_front();
            rsp_got  = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16]};
            check_field("red_out", rsp_want.red, rsp_got.red);
            check_field("green_out", rsp_want.green, rsp_got.green);
            check_field("blue_out", rsp_want.blue, rsp_got.blue);
         end
      end
      if (hold_rsp_long) begin
         hold_rsp_long = 1'b0;
         rsp_hold      = LONG_HOLD;
         rsp_steady    = 0;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_steady > 0) begin
         rsp_steady--;
         rsp_tready <= 1'b1;
      end else begin
         rsp_roll = $urandom_range(0, 29);
         if (rsp_roll == 0) begin
            rsp_steady = $urandom_range(20, 80);
            rsp_tready <= 1'b1;
         end else if (rsp_roll < 8) begin
            rsp_hold = stall_length() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------

   initial begin
      // Directed table; rgb_type literals are {red, green, blue}
      // map straight after reset: zero maxima, so any nonzero count saturates
      add_pixel_row(MODE_MAP, 1'b0, 24'h0, 24'h1, 24'hFFFFFF, 1'b1, {8'd0, 8'd255, 8'd255});
      // start flag on a map transfer is ignored
      add_pixel_row(MODE_MAP, 1'b1, 24'h5, 24'h0, 24'h0, 1'b1, {8'd255, 8'd0, 8'd0});
      // full-scale maxima: factor rounds down to zero
      add_pixel_row(MODE_MEASURE, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'hFFFFFF, 24'h0, 24'h1, 1'b1, {8'd0, 8'd0, 8'd0});
      // maxima of 255 at unity gain: factor of one
      add_pixel_row(MODE_MEASURE, 1'b1, 24'hFF, 24'hFF, 24'hFF, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'hFF, 24'h1, 24'h0, 1'b1, {8'd255, 8'd1, 8'd0});
      // continue the frame without a start flag
      add_pixel_row(MODE_MEASURE, 1'b0, 24'h3E8, 24'hA, 24'h0, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'h3E8, 24'h64, 24'h12C, 1'b0, '0);
      add_pixel_row(MODE_MEASURE, 1'b1, 24'h0, 24'h0, 24'h0, 1'b0, '0);
      add_pixel_row(MODE_MEASURE, 1'b0, 24'h1, 24'h2, 24'h3, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'h1, 24'h2, 24'h3, 1'b0, '0);
      // largest gain: a maximum below the gain divides down to zero
      add_gain_row(8'd255);
      add_pixel_row(MODE_MEASURE, 1'b1, 24'hFE, 24'h1FE, 24'hFFFFFF, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'hFE, 24'h1FE, 24'hFFFFFF, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b1, 24'h0, 24'h1, 24'h10000, 1'b0, '0);
      // gain register of zero behaves as one
      add_gain_row(8'd0);
      add_pixel_row(MODE_MEASURE, 1'b1, 24'h64, 24'hC8, 24'h32, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'h64, 24'h0, 24'h19, 1'b0, '0);
      // start flag in the middle of a measure pass clears the maxima again
      add_pixel_row(MODE_MEASURE, 1'b0, 24'hAAAAAA, 24'h555555, 24'h800000, 1'b0, '0);
      add_pixel_row(MODE_MEASURE, 1'b1, 24'h5, 24'h6, 24'h7, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'h5, 24'h6, 24'h7, 1'b0, '0);
      add_gain_row(8'd16);
      add_pixel_row(MODE_MEASURE, 1'b1, 24'h800000, 24'h7FFFFF, 24'h10, 1'b0, '0);
      add_pixel_row(MODE_MAP, 1'b0, 24'h400000, 24'h7FFFFF, 24'h1, 1'b0, '0);

      // Hold reset, once, then release it
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_GAIN)
            write_gain(directed_rows[i].gain);
         else
            send_pixel(directed_rows[i].pix, directed_rows[i].known, directed_rows[i].want);
      end

      // Random phases: new gain while idle, then one to four frames under it
      while (pixels_sent < TARGET_ITEMS) begin
         write_gain(pick_gain());
         repeat ($urandom_range(1, 4)) begin
            if (!hold_done && pixels_sent > 200) begin
               hold_done = 1'b1;
               run_frame(1'b1);
            end else begin
               run_frame(1'b0);
            end
         end
      end

      wait_idle();
      $display("Covered %0d pixel transfers (%0d measure, %0d map) under %0d gain writes;",
               pixels_sent, measures_sent, maps_sent, gain_writes);
      $display("%0d results checked, %0d errors, %0d cycles.", results_seen, errors,
               cycle_count);
      if (errors == 0 && expected_rgb.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
hdl/rmn_pkg.sv
hdl/rmn_ctrl.sv
hdl/rmn_datapath.sv
hdl/rgb_max_normalize_with_gain.sv
hdl/rmn_checker.sv
tb/rgb_max_normalize_with_gain_test.sv
